// ===== rtl/cjp_pkg.sv =====
// Shared types and constants for the Collatz jump polynomial block.
// Used by cjp_step_unit and collatz_jump_polynomial; no dependencies.
`default_nettype none

package cjp_pkg;

    // running value width; trajectories of 31-bit residues stay below 2^51
    localparam int XW    = 54;
    localparam int ADD_W = 52;
    localparam int CNT_W = 5;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_RESIDUE_WIDTH = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ODD_STEP_CAP  = 8'd1;

    // bit length of 3^n; 3^n < 2^b exactly when b >= POW3_BITS[n]
    localparam logic [5:0] POW3_BITS [32] = '{
        6'd1,  6'd2,  6'd4,  6'd5,  6'd7,  6'd8,  6'd10, 6'd12,
        6'd13, 6'd15, 6'd16, 6'd18, 6'd20, 6'd21, 6'd23, 6'd24,
        6'd26, 6'd27, 6'd29, 6'd31, 6'd32, 6'd34, 6'd35, 6'd37,
        6'd39, 6'd40, 6'd42, 6'd43, 6'd45, 6'd46, 6'd48, 6'd50
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_LOOKUP,
        ST_FINISH
    } t_state;

    // per-step status from the step unit
    typedef struct packed {
        logic odd;   // this step was 3x+1
        logic take;  // new peak point
        logic dip;   // 3^a < 2^b after this halving
    } t_step_stat;

endpackage

`default_nettype wire

// ===== rtl/cjp_step_unit.sv =====
// One Collatz step: 3x+1 or halving, plus exact peak and dip ratio tests.
// Depends on cjp_pkg (widths, 3^n bit-length table, status struct).
`default_nettype none

module cjp_step_unit (
    input  wire logic [cjp_pkg::XW-1:0]    i_x,
    input  wire logic [cjp_pkg::CNT_W-1:0] i_p3,
    input  wire logic [cjp_pkg::CNT_W-1:0] i_p2,
    input  wire logic [cjp_pkg::CNT_W-1:0] i_k3,
    input  wire logic [cjp_pkg::CNT_W-1:0] i_k2,
    input  wire logic                      i_found,
    input  wire logic [cjp_pkg::CNT_W-1:0] i_cap,
    output logic      [cjp_pkg::XW-1:0]    o_x,
    output logic      [cjp_pkg::CNT_W-1:0] o_p3,
    output logic      [cjp_pkg::CNT_W-1:0] o_p2,
    output cjp_pkg::t_step_stat            o_stat
);

    logic                      w_odd;
    logic [cjp_pkg::CNT_W-1:0] w_p3_inc;
    logic [cjp_pkg::CNT_W-1:0] w_d3;
    logic [cjp_pkg::CNT_W-1:0] w_d2;
    logic                      w_ratio_gt;
    logic                      w_above_one;
    logic                      w_cap_on;
    logic [cjp_pkg::CNT_W:0]   w_p2_inc;

    always_comb begin
        w_odd    = i_x[0];
        w_p3_inc = (i_p3 == {cjp_pkg::CNT_W{1'b1}}) ? i_p3 : i_p3 + 1'b1;
        w_p2_inc = {1'b0, i_p2} + 1'b1;

        // ratio of new point against best so far: 3^(p-k) > 2^(b-k)
        w_d3       = w_p3_inc - i_k3;
        w_d2       = i_p2 - i_k2;
        w_ratio_gt = (w_d3 != '0) && ({1'b0, w_d2} < cjp_pkg::POW3_BITS[w_d3]);
        // 3^p > 2^b
        w_above_one = (w_p3_inc != '0) && ({1'b0, i_p2} < cjp_pkg::POW3_BITS[w_p3_inc]);
        w_cap_on    = (i_cap != '0);

        o_stat.odd  = w_odd;
        o_stat.take = 1'b0;
        o_stat.dip  = 1'b0;
        if (w_odd) begin
            o_x  = {i_x[cjp_pkg::XW-2:0], 1'b0} + i_x + cjp_pkg::XW'(1);
            o_p3 = w_p3_inc;
            o_p2 = i_p2;
            if (w_cap_on && (w_p3_inc == i_cap)) begin
                o_stat.take = !i_found || w_ratio_gt;
            end else if (w_cap_on && (w_p3_inc > i_cap)) begin
                o_stat.take = 1'b0;
            end else begin
                o_stat.take = w_above_one && w_ratio_gt;
            end
        end else begin
            o_x        = {1'b0, i_x[cjp_pkg::XW-1:1]};
            o_p3       = i_p3;
            o_p2       = w_p2_inc[cjp_pkg::CNT_W-1:0];
            o_stat.dip = (w_p2_inc >= cjp_pkg::POW3_BITS[i_p3]);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/collatz_jump_polynomial.sv =====
// Top level of the Collatz jump polynomial block: sequencer, per-count store,
// output register. Depends on cjp_pkg and cjp_step_unit.
`default_nettype none

// Collatz jump polynomial. Each input transaction carries a residue that is
// masked to residue_width bits (width saturated to MAX_WIDTH) and then run
// through Collatz steps, one step per clock through a single shared step
// unit, until residue_width halvings are done. From acceptance to the next
// possible acceptance an item passes through the step loop, the registered
// lookup of the per-odd-count store, and a finish cycle that loads the
// output register. s_tready is high only while idle; a result waiting in the
// output register does not block acceptance, but the next item holds in its
// finish cycle until the register is free. The store keeps the last constant
// seen for each odd count; a valid bit per entry, cleared at reset, makes
// unwritten entries read as zero. Configuration writes are always ready and
// should only be issued while the block is idle.
module collatz_jump_polynomial #(
    parameter int MAX_WIDTH = 31
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // config write channel
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [7:0]   i_cfg_index,
    input  wire logic [7:0]   i_cfg_data,
    // input stream
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [31:0]  i_s_tdata,   // [30:0] start_residue, [31] zero pad
    // output stream
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // [4:0] odd_count, [56:5] add_term, [57] dipped_below, [58] ends_below,
    // [59] repeat_of_last, [64:60] peak_odd_count, [69:65] peak_halvings,
    // [121:70] peak_add_term, [122] peak_above_one, [127:123] zero pad
    output logic      [127:0] o_m_tdata
);

    localparam int XW    = cjp_pkg::XW;
    localparam int ADD_W = cjp_pkg::ADD_W;
    localparam int CW    = cjp_pkg::CNT_W;
    localparam int DEPTH = 1 << CW;

    // config registers
    logic [CW-1:0] r_residue_width;
    logic [CW-1:0] r_odd_step_cap;

    // sequencer
    cjp_pkg::t_state r_state, n_state;

    // working registers
    logic [XW-1:0] r_x, n_x;
    logic [CW-1:0] r_p3, n_p3;
    logic [CW-1:0] r_p2, n_p2;
    logic [CW-1:0] r_k3, n_k3;
    logic [CW-1:0] r_k2, n_k2;
    logic [XW-1:0] r_kadd, n_kadd;
    logic          r_found, n_found;
    logic          r_dipped, n_dipped;
    logic [CW-1:0] r_remaining, n_remaining;
    logic [CW-1:0] r_width;  // clamped width of the current item

    // per-odd-count store
    logic [ADD_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_entry_valid;
    logic [ADD_W-1:0] r_rd_data;
    logic             r_rd_valid;

    // output register
    logic         r_out_valid, n_out_valid;
    logic [127:0] r_out_data, n_out_data;

    // decodes
    logic s_accept;
    logic s_step;
    logic s_lookup;
    logic s_finish;
    logic s_out_free;

    logic [CW-1:0]  w_width;
    logic [30:0]    w_residue;
    logic [XW-1:0]  w_step_x;
    logic [CW-1:0]  w_step_p3;
    logic [CW-1:0]  w_step_p2;
    cjp_pkg::t_step_stat w_stat;

    logic [ADD_W-1:0] w_final_add;
    logic [ADD_W-1:0] w_stored;
    logic             w_repeat;
    logic             w_ends;
    logic [CW-1:0]    w_pk3;
    logic [CW-1:0]    w_pk2;
    logic [ADD_W-1:0] w_pkadd;
    logic             w_pk_above;

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_residue_width <= 5'd16;
            r_odd_step_cap  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cjp_pkg::CFG_RESIDUE_WIDTH: r_residue_width <= i_cfg_data[CW-1:0];
                cjp_pkg::CFG_ODD_STEP_CAP:  r_odd_step_cap  <= i_cfg_data[CW-1:0];
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // ----------------------------------------------------------- step unit
    cjp_step_unit u_step (
        .i_x     (r_x),
        .i_p3    (r_p3),
        .i_p2    (r_p2),
        .i_k3    (r_k3),
        .i_k2    (r_k2),
        .i_found (r_found),
        .i_cap   (r_odd_step_cap),
        .o_x     (w_step_x),
        .o_p3    (w_step_p3),
        .o_p2    (w_step_p2),
        .o_stat  (w_stat)
    );

    // ------------------------------------------------------ sequencer decode
    always_comb begin
        s_out_free = !r_out_valid || i_m_tready;
        o_s_tready = (r_state == cjp_pkg::ST_IDLE);
        s_accept   = i_s_tvalid && o_s_tready;
        s_step     = (r_state == cjp_pkg::ST_RUN);
        s_lookup   = (r_state == cjp_pkg::ST_LOOKUP);
        s_finish   = (r_state == cjp_pkg::ST_FINISH) && s_out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cjp_pkg::ST_IDLE: begin
                if (s_accept) begin
                    n_state = (w_width == '0) ? cjp_pkg::ST_LOOKUP : cjp_pkg::ST_RUN;
                end
            end
            cjp_pkg::ST_RUN: begin
                // last halving ends the run
                if (!w_stat.odd && (r_remaining == CW'(1))) begin
                    n_state = cjp_pkg::ST_LOOKUP;
                end
            end
            cjp_pkg::ST_LOOKUP: n_state = cjp_pkg::ST_FINISH;
            cjp_pkg::ST_FINISH: begin
                if (s_out_free) begin
                    n_state = cjp_pkg::ST_IDLE;
                end
            end
            default: n_state = cjp_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------ datapath
    always_comb begin
        w_width   = (r_residue_width > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : r_residue_width;
        w_residue = i_s_tdata[30:0] & ~({31{1'b1}} << w_width);

        n_x         = r_x;
        n_p3        = r_p3;
        n_p2        = r_p2;
        n_k3        = r_k3;
        n_k2        = r_k2;
        n_kadd      = r_kadd;
        n_found     = r_found;
        n_dipped    = r_dipped;
        n_remaining = r_remaining;

        if (s_accept) begin
            n_x         = XW'(w_residue);
            n_p3        = '0;
            n_p2        = '0;
            n_k3        = '0;
            n_k2        = '0;
            n_kadd      = '0;
            n_found     = 1'b0;
            n_dipped    = 1'b0;
            n_remaining = w_width;
        end else if (s_step) begin
            n_x  = w_step_x;
            n_p3 = w_step_p3;
            n_p2 = w_step_p2;
            if (w_stat.take) begin
                n_k3    = w_step_p3;
                n_k2    = w_step_p2;
                n_kadd  = w_step_x;
                n_found = 1'b1;
            end
            if (w_stat.dip) begin
                n_dipped = 1'b1;
            end
            if (!w_stat.odd) begin
                n_remaining = r_remaining - 1'b1;
            end
        end
    end

    // finish: repeat check, peak selection, result packing
    always_comb begin
        w_final_add = r_x[ADD_W-1:0];
        w_stored    = r_rd_valid ? r_rd_data : '0;
        w_repeat    = (r_p3 != '0) && (w_stored == w_final_add);
        w_ends      = ({1'b0, r_p2} >= cjp_pkg::POW3_BITS[r_p3]);
        w_pk3       = r_found ? r_k3 : r_p3;
        w_pk2       = r_found ? r_k2 : r_p2;
        w_pkadd     = r_found ? r_kadd[ADD_W-1:0] : w_final_add;
        w_pk_above  = (w_pk3 != '0) && ({1'b0, w_pk2} < cjp_pkg::POW3_BITS[w_pk3]);

        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (s_finish) begin
            n_out_valid = 1'b1;
            n_out_data  = {5'd0, w_pk_above, w_pkadd, w_pk2, w_pk3,
                           w_repeat, w_ends, r_dipped, w_final_add, r_p3};
        end
    end

    // ----------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= cjp_pkg::ST_IDLE;
            r_out_valid   <= 1'b0;
            r_entry_valid <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (s_finish && !w_repeat) begin
                r_entry_valid[r_p3] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x         <= n_x;
        r_p3        <= n_p3;
        r_p2        <= n_p2;
        r_k3        <= n_k3;
        r_k2        <= n_k2;
        r_kadd      <= n_kadd;
        r_found     <= n_found;
        r_dipped    <= n_dipped;
        r_remaining <= n_remaining;
        r_out_data  <= n_out_data;
        if (s_accept) begin
            r_width <= w_width;
        end
    end

    // store: registered read during lookup, write on a non-repeat finish
    always_ff @(posedge i_clk) begin
        if (s_lookup) begin
            r_rd_data  <= r_mem[r_p3];
            r_rd_valid <= r_entry_valid[r_p3];
        end
        if (s_finish && !w_repeat) begin
            r_mem[r_p3] <= w_final_add;
        end
    end

    // ---------------------------------------------------------- assertions
`ifndef ASSERT_OFF
    // an accepted item keeps the block busy in the cycle after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready right after an accepted transaction");

    // a result appears only out of the finish cycle
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == cjp_pkg::ST_FINISH))
        else $error("output valid rose outside the finish cycle");

    // halvings never run past the item's width
    a_halvings_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cjp_pkg::ST_RUN) |-> (r_p2 < r_width))
        else $error("halving count reached width while still running");

    // the store is written only when the output register can take the result
    a_write_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_finish |=> o_m_tvalid)
        else $error("finish cycle did not load the output register");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for collatz_jump_polynomial: directed table, then random phases.
// Predicts every result with its own Collatz jump model and compares each output field.
// Depends on cjp_pkg and the collatz_jump_polynomial RTL.
`default_nettype none

module testbench;

    localparam int MAX_WIDTH   = 31;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 50;
    localparam int DRAIN_CYCLES = 70;   // one full item at the widest setting

    // one result transaction, laid out as o_m_tdata (first member is the top bits)
    typedef struct packed {
        logic [4:0]                pad;
        logic                      peak_above_one;
        logic [cjp_pkg::ADD_W-1:0] peak_add_term;
        logic [cjp_pkg::CNT_W-1:0] peak_halvings;
        logic [cjp_pkg::CNT_W-1:0] peak_odd_count;
        logic                      repeat_of_last;
        logic                      ends_below;
        logic                      dipped_below;
        logic [cjp_pkg::ADD_W-1:0] add_term;
        logic [cjp_pkg::CNT_W-1:0] odd_count;
    } t_jump;

    typedef struct packed {
        logic [4:0]  width;
        logic [4:0]  cap;
        logic [30:0] residue;
        logic        known;
        t_jump       want;
    } t_row;

    // results that follow from the rules without working through the steps
    localparam t_jump ZEROS_W16 = '{pad: '0, peak_above_one: 1'b0, peak_add_term: '0,
        peak_halvings: 5'd16, peak_odd_count: '0, repeat_of_last: 1'b0, ends_below: 1'b1,
        dipped_below: 1'b1, add_term: '0, odd_count: '0};
    localparam t_jump ZEROS_W31 = '{pad: '0, peak_above_one: 1'b0, peak_add_term: '0,
        peak_halvings: 5'd31, peak_odd_count: '0, repeat_of_last: 1'b0, ends_below: 1'b1,
        dipped_below: 1'b1, add_term: '0, odd_count: '0};
    // width 1, residue 1: 1 -> 4 (peak 3/1) -> 2
    localparam t_jump ONE_NEW = '{pad: '0, peak_above_one: 1'b1, peak_add_term: 52'd4,
        peak_halvings: 5'd0, peak_odd_count: 5'd1, repeat_of_last: 1'b0, ends_below: 1'b0,
        dipped_below: 1'b0, add_term: 52'd2, odd_count: 5'd1};
    localparam t_jump ONE_AGAIN = '{pad: '0, peak_above_one: 1'b1, peak_add_term: 52'd4,
        peak_halvings: 5'd0, peak_odd_count: 5'd1, repeat_of_last: 1'b1, ends_below: 1'b0,
        dipped_below: 1'b0, add_term: 52'd2, odd_count: 5'd1};

    localparam int ROWS = 20;
    localparam t_row DIRECTED [ROWS] = '{
        '{5'd16, 5'd0,  31'h0000_0000, 1'b1, ZEROS_W16},
        '{5'd16, 5'd0,  31'h7FFF_FFFF, 1'b0, '0},         // masked to 16 ones
        '{5'd16, 5'd0,  31'h0001_0000, 1'b1, ZEROS_W16},  // above range, masks to zero
        '{5'd0,  5'd0,  31'h7FFF_FFFF, 1'b1, '0},         // zero width: nothing runs
        '{5'd0,  5'd0,  31'h0000_0000, 1'b1, '0},
        '{5'd1,  5'd0,  31'h0000_0001, 1'b1, ONE_NEW},
        '{5'd1,  5'd0,  31'h0000_0003, 1'b1, ONE_AGAIN},  // same constant again
        '{5'd31, 5'd0,  31'h7FFF_FFFF, 1'b0, '0},         // most odd steps
        '{5'd31, 5'd0,  31'h0000_0000, 1'b1, ZEROS_W31},
        '{5'd31, 5'd0,  31'h4000_0000, 1'b0, '0},
        '{5'd31, 5'd0,  31'h7FFF_FFFF, 1'b0, '0},
        '{5'd31, 5'd31, 31'h7FFF_FFFF, 1'b0, '0},
        '{5'd31, 5'd1,  31'h7FFF_FFFF, 1'b0, '0},         // cap hit at the first odd step
        '{5'd31, 5'd1,  31'h2AAA_AAAA, 1'b0, '0},
        '{5'd31, 5'd0,  31'h0000_001B, 1'b0, '0},
        '{5'd8,  5'd3,  31'h0000_00B7, 1'b0, '0},
        '{5'd5,  5'd2,  31'h0000_001B, 1'b0, '0},
        '{5'd31, 5'd5,  31'h5555_5555, 1'b0, '0},
        '{5'd12, 5'd0,  31'h0000_07FF, 1'b0, '0},
        '{5'd31, 5'd30, 31'h7FFF_FFFE, 1'b0, '0}
    };

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_index;
    logic [7:0]   i_cfg_data;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [31:0]  i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [127:0] o_m_tdata;

    // predictor state: configuration and last constant per odd count
    logic [4:0]                res_width;
    logic [4:0]                cap_count;
    logic [cjp_pkg::ADD_W-1:0] last_add [32];

    t_jump jump_q [$];          // expected results, oldest first
    int    errors;
    int    cycles;
    int    hold_requests;       // bumped by the stimulus to ask for one long hold-off
    bit    steady;              // no idling on either side while set
    bit    have_known;          // the item on offer carries a typed-in result
    t_jump known_jump;

    collatz_jump_polynomial uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic longint unsigned pow_n(input int unsigned base, input int unsigned n);
        longint unsigned v;
        v = 1;
        for (int unsigned i = 0; i < (n & 31); i++)
            v = v * base;
        return v;
    endfunction

    // 3^a3/2^a2 > 3^b3/2^b2, with a3 >= b3 and a2 >= b2
    function automatic bit ratio_beats(input int unsigned a3, a2, b3, b2);
        return pow_n(3, a3 - b3) > pow_n(2, a2 - b2);
    endfunction

    // Runs one residue through the jump and updates the per-count store.
    function automatic t_jump predict_jump(input logic [30:0] residue);
        int unsigned     w, left, p3, p2, m3, m2;
        longint unsigned x;
        bit              found, dip, take;
        t_jump           res;
        res = '0;
        w = (res_width > MAX_WIDTH) ? MAX_WIDTH : res_width;
        x = 64'(residue) & ((64'd1 << w) - 64'd1);
        left = w;
        p3 = 0;
        p2 = 0;
        m3 = 0;
        m2 = 0;
        found = 1'b0;
        dip = 1'b0;
        while (left > 0) begin
            if (x[0]) begin
                x = 3 * x + 1;
                if (p3 < 31)
                    p3++;
                // past the cap the search is over; at the cap the first point counts
                if (cap_count == 0 || p3 < cap_count)
                    take = pow_n(3, p3) > pow_n(2, p2) && ratio_beats(p3, p2, m3, m2);
                else if (p3 == cap_count)
                    take = !found || ratio_beats(p3, p2, m3, m2);
                else
                    take = 1'b0;
                if (take) begin
                    found = 1'b1;
                    m3 = p3;
                    m2 = p2;
                    res.peak_add_term = x[cjp_pkg::ADD_W-1:0];
                end
            end else begin
                x = x >> 1;
                left--;
                p2++;
                if (pow_n(3, p3) < pow_n(2, p2))
                    dip = 1'b1;
            end
        end
        res.odd_count    = p3[4:0];
        res.add_term     = x[cjp_pkg::ADD_W-1:0];
        res.dipped_below = dip;
        res.ends_below   = pow_n(3, p3) < pow_n(2, p2);
        if (p3 != 0 && last_add[p3[4:0]] == x[cjp_pkg::ADD_W-1:0])
            res.repeat_of_last = 1'b1;
        else
            last_add[p3[4:0]] = x[cjp_pkg::ADD_W-1:0];
        if (!found) begin
            m3 = p3;
            m2 = p2;
            res.peak_add_term = x[cjp_pkg::ADD_W-1:0];
        end
        res.peak_odd_count = m3[4:0];
        res.peak_halvings  = m2[4:0];
        res.peak_above_one = pow_n(3, m3) > pow_n(2, m2);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch in %s at cycle %0d: got %0h, expected %0h", what, cycles, got, want);
        errors++;
    endtask

    task automatic check_jump(input t_jump got, input t_jump want);
        if (got.odd_count != want.odd_count)
            report_mismatch("odd_count", got.odd_count, want.odd_count);
        if (got.add_term != want.add_term)
            report_mismatch("add_term", got.add_term, want.add_term);
        if (got.dipped_below != want.dipped_below)
            report_mismatch("dipped_below", got.dipped_below, want.dipped_below);
        if (got.ends_below != want.ends_below)
            report_mismatch("ends_below", got.ends_below, want.ends_below);
        if (got.repeat_of_last != want.repeat_of_last)
            report_mismatch("repeat_of_last", got.repeat_of_last, want.repeat_of_last);
        if (got.peak_odd_count != want.peak_odd_count)
            report_mismatch("peak_odd_count", got.peak_odd_count, want.peak_odd_count);
        if (got.peak_halvings != want.peak_halvings)
            report_mismatch("peak_halvings", got.peak_halvings, want.peak_halvings);
        if (got.peak_add_term != want.peak_add_term)
            report_mismatch("peak_add_term", got.peak_add_term, want.peak_add_term);
        if (got.peak_above_one != want.peak_above_one)
            report_mismatch("peak_above_one", got.peak_above_one, want.peak_above_one);
    endtask

    // Monitor: all handshakes are observed here, at the rising edge.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench NOT OK");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    cjp_pkg::CFG_RESIDUE_WIDTH: res_width = i_cfg_data[4:0];
                    cjp_pkg::CFG_ODD_STEP_CAP:  cap_count = i_cfg_data[4:0];
                    default: ;   // unknown index: no register changes
                endcase
            end
            // check before push, so a stray result never meets a fresh expectation
            if (o_m_tvalid && i_m_tready) begin
                if (jump_q.size() == 0)
                    report_mismatch("result with nothing expected", o_m_tdata[63:0], 0);
                else
                    check_jump(t_jump'(o_m_tdata), jump_q.pop_front());
            end
            if (i_s_tvalid && o_s_tready) begin
                if (have_known) begin
                    void'(predict_jump(i_s_tdata[30:0]));   // keeps the store in step
                    jump_q.push_back(known_jump);
                end else begin
                    jump_q.push_back(predict_jump(i_s_tdata[30:0]));
                end
            end
        end
    end

    // Result side: random back-pressure, plus a long hold-off on request.
    initial begin
        int holds_done;
        holds_done = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done++;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                i_m_tready <= steady || ($urandom_range(99) >= 25);
            end
        end
    end

    // Waits for the block to go idle, then performs one register write transaction.
    task automatic write_reg(input logic [7:0] index, input logic [7:0] data);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (jump_q.size() != 0)
            @(negedge i_clk);
        i_cfg_index <= index;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Upper data bits are junk: only the low five bits should count.
    task automatic set_mode(input logic [4:0] width, input logic [4:0] cap);
        write_reg(cjp_pkg::CFG_RESIDUE_WIDTH, {3'($urandom), width});
        write_reg(cjp_pkg::CFG_ODD_STEP_CAP, {3'($urandom), cap});
    endtask

    // Offers one residue and returns at the edge where it is taken.
    task automatic send_residue(input logic [30:0] residue, input bit known,
                                input t_jump want);
        int gap;
        gap = (!steady && $urandom_range(99) < 25) ? $urandom_range(6, 1) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= {1'b0, 31'($urandom)};
        end
        @(negedge i_clk);
        have_known = known;
        known_jump = want;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, residue};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic wait_drained;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (jump_q.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        logic [30:0] recent [8];
        logic [30:0] residue;
        logic [4:0]  width;
        logic [4:0]  cap;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        errors        = 0;
        cycles        = 0;
        hold_requests = 0;
        steady        = 1'b0;
        have_known    = 1'b0;
        known_jump    = '0;
        res_width     = 5'd16;
        cap_count     = 5'd0;
        for (int i = 0; i < 32; i++)
            last_add[i] = '0;
        for (int i = 0; i < 8; i++)
            recent[i] = 31'($urandom);
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; settings change only between rows that need it
        for (int i = 0; i < ROWS; i++) begin
            if (DIRECTED[i].width != res_width || DIRECTED[i].cap != cap_count)
                set_mode(DIRECTED[i].width, DIRECTED[i].cap);
            send_residue(DIRECTED[i].residue, DIRECTED[i].known, DIRECTED[i].want);
        end
        // a write to an index that does not exist must leave both registers alone
        write_reg(8'hA5, 8'hFF);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    width = 5'd31;
                    cap   = 5'd0;
                end
                1: begin
                    width = 5'd1;
                    cap   = 5'd31;
                end
                default: begin
                    width = 5'($urandom_range(31));
                    cap   = ($urandom_range(1) != 0) ? 5'd0 : 5'($urandom_range(31, 1));
                end
            endcase
            set_mode(width, cap);
            steady = (ph == 0);
            // block fills behind a stalled result port while items keep coming
            if (ph == 2)
                hold_requests++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 3 && n == PHASE_ITEMS / 2)
                    wait_drained();
                case ($urandom_range(3))
                    0:       residue = recent[$urandom_range(7)];   // invites repeats
                    1:       residue = 31'($urandom) | 31'((64'd1 << width) - 1);
                    default: residue = 31'($urandom);
                endcase
                recent[n % 8] = residue;
                send_residue(residue, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
